/* src/rme_pkg.sv */
// ---------------------------------------------------------------------------
// rme_pkg: shared types and constants for the rate matrix exponential block
// Request codes, status codes and Q8.24 fixed point constants.
// ---------------------------------------------------------------------------
package rme_pkg;

  localparam int NUM_STATES = 4;
  localparam int IDX_W      = 4;   // row and column index of a 4x4 matrix
  localparam int DATA_W     = 32;
  localparam int SUM_W      = 36;

  typedef enum logic [1:0] {
    REQ_WR_RATE = 2'd0,
    REQ_WR_STAT = 2'd1,
    REQ_COMPUTE = 2'd2,
    REQ_READ    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_RATE_ROW = 2'd1,
    STAT_RES_ROW  = 2'd2
  } status_t;

  localparam logic signed [63:0] ONE_Q24    = 64'sd16777216;
  localparam logic signed [35:0] TOL_LSB    = 36'sd167;
  localparam logic [3:0]         MAX_SHIFTS = 4'd10;
  localparam logic signed [63:0] LONG_LIMIT = 64'sd300 <<< 48;

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    logic [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

/* src/rme_ram.sv */
// ---------------------------------------------------------------------------
// rme_ram: simple dual port synchronous RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module rme_ram #(
  parameter int AW = 4,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata_r
);

  logic [DW-1:0] mem [1 << AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

/* src/rme_mul.sv */
// ---------------------------------------------------------------------------
// rme_mul: shared registered multiplier
// Signed 33x33 product, kept to 64 bits since operands stay within 2^31.
// ---------------------------------------------------------------------------
module rme_mul (
  input  logic               clk,
  input  logic signed [32:0] op_a,
  input  logic signed [32:0] op_b,
  output logic signed [63:0] prod_r
);

  logic signed [65:0] prod_full;

  assign prod_full = op_a * op_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_full[63:0];
  end

endmodule

/* src/rate_matrix_exponential.sv */
// ---------------------------------------------------------------------------
// rate_matrix_exponential: exp(t*Q) by scaling and squaring in Q8.24
// Requests on the in_ channel load rate and stationary entries, start a
// compute with branch length in_value, or read a result entry.
// Loads give no result. A read gives one result entry through the output
// register. A compute gives one result with the status and the squaring
// count; it checks the rate rows (ending there on a failure), tests for a
// long branch, picks the scale, builds the scaled matrix, squares it (64
// multiplies through the one shared multiplier and a 16 entry copy back
// per squaring), checks the result rows and loads the output. A long
// branch instead fills the result rows with the stationary vector.
// The block works on one request at a time and takes a new one only when
// the output register is free or being emptied, so a stalled receiver
// holds the block. Reset clears control state and the stored status; the
// matrices are undefined until written.
// ---------------------------------------------------------------------------
module rate_matrix_exponential (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [1:0]  in_row,
  input  logic [1:0]  in_col,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_entry_value,
  output logic [3:0]  out_squarings
);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_READ   = 11'b000_0000_0010,
    ST_CHKQ   = 11'b000_0000_0100,
    ST_DECIDE = 11'b000_0000_1000,
    ST_SSEL   = 11'b000_0001_0000,
    ST_PIFILL = 11'b000_0010_0000,
    ST_SCALE  = 11'b000_0100_0000,
    ST_SQUARE = 11'b000_1000_0000,
    ST_COPY   = 11'b001_0000_0000,
    ST_CHKR   = 11'b010_0000_0000,
    ST_DONE   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic        acc_in;
  logic [6:0]  cnt_r, lim;
  logic        sweep, iss, drained;
  logic [3:0]  iss_idx;
  logic [1:0]  iss_k;

  logic        s1_v_r, s2_v_r, s2_diag_r;
  logic [3:0]  s1_idx_r, s2_idx_r;
  logic [1:0]  s1_k_r, s2_k_r;
  logic        s1_diag;

  logic signed [31:0] t_r;
  logic [3:0]  s_r, sq_cnt_r;
  logic        fail_r;
  logic signed [35:0] sum_r;
  logic signed [63:0] maxdiag_r;
  logic [63:0] m100_r;
  logic signed [63:0] acc_r;
  logic [1:0]  last_status_r, status_r;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_entry_r;
  logic [3:0]  out_sq_r;

  logic [31:0] rate_rd, pi_rd, res_rd_a, res_rd_b, scr_rd;
  logic        rate_we, pi_we, res_we, scr_we;
  logic [3:0]  rate_waddr, res_waddr, rate_raddr, res_raddr_a, res_raddr_b;
  logic [31:0] rate_wdata, res_wdata, scr_wdata;
  logic [1:0]  pi_waddr;

  logic signed [32:0] mul_a, mul_b;
  logic signed [63:0] prod;

  logic signed [31:0] sum_data;
  logic signed [35:0] sum_tot, sum_diff, sum_tgt;
  logic        row_bad;

  logic [5:0]  sc_n;
  logic signed [63:0] sc_v, sq_r, sq_acc;

  assign acc_in   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);

  // Sweep phases issue memory reads from a counter and drain a two stage
  // pipeline before the next phase starts, which keeps writes and reads
  // of the same memory from overlapping.
  assign sweep = (state_r == ST_CHKQ) || (state_r == ST_PIFILL) ||
                 (state_r == ST_SCALE) || (state_r == ST_SQUARE) ||
                 (state_r == ST_COPY) || (state_r == ST_CHKR);
  assign lim     = (state_r == ST_SQUARE) ? 7'd64 : 7'd16;
  assign iss     = sweep && (cnt_r < lim);
  assign drained = sweep && (cnt_r == lim) && !s1_v_r && !s2_v_r;
  assign iss_idx = (state_r == ST_SQUARE) ? cnt_r[5:2] : cnt_r[3:0];
  assign iss_k   = cnt_r[1:0];
  assign s1_diag = (s1_idx_r[3:2] == s1_idx_r[1:0]);

  // Memories.
  assign rate_we    = acc_in && (in_req_type == rme_pkg::REQ_WR_RATE);
  assign rate_waddr = {in_row, in_col};
  assign rate_wdata = in_value;
  assign rate_raddr = iss_idx;
  assign pi_we      = acc_in && (in_req_type == rme_pkg::REQ_WR_STAT);
  assign pi_waddr   = in_row;

  assign res_raddr_a = (state_r == ST_IDLE) ? {in_row, in_col} :
                       (state_r == ST_SQUARE) ? {iss_idx[3:2], iss_k} : iss_idx;
  assign res_raddr_b = {iss_k, iss_idx[1:0]};

  rme_ram #(.AW(4), .DW(32)) u_rate (
    .clk(clk), .we(rate_we), .waddr(rate_waddr), .wdata(rate_wdata),
    .raddr(rate_raddr), .rdata_r(rate_rd)
  );

  rme_ram #(.AW(2), .DW(32)) u_pi (
    .clk(clk), .we(pi_we), .waddr(pi_waddr), .wdata(in_value),
    .raddr(iss_idx[1:0]), .rdata_r(pi_rd)
  );

  // The result matrix is held twice to give two read ports.
  rme_ram #(.AW(4), .DW(32)) u_res_a (
    .clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
    .raddr(res_raddr_a), .rdata_r(res_rd_a)
  );

  rme_ram #(.AW(4), .DW(32)) u_res_b (
    .clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
    .raddr(res_raddr_b), .rdata_r(res_rd_b)
  );

  rme_ram #(.AW(4), .DW(32)) u_scr (
    .clk(clk), .we(scr_we), .waddr(s2_idx_r), .wdata(scr_wdata),
    .raddr(iss_idx), .rdata_r(scr_rd)
  );

  // Multiplier operands are taken straight from the read data.
  always_comb begin
    mul_a = 33'sd0;
    mul_b = 33'(t_r);
    case (state_r)
      ST_CHKQ: begin
        mul_a = rate_rd[31] ? -33'(signed'(rate_rd)) : 33'(signed'(rate_rd));
      end
      ST_SCALE: begin
        mul_a = 33'(signed'(rate_rd));
      end
      ST_SQUARE: begin
        mul_a = 33'(signed'(res_rd_a));
        mul_b = 33'(signed'(res_rd_b));
      end
      default: begin
        mul_a = 33'sd0;
      end
    endcase
  end

  rme_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod_r(prod));

  // Row sum check, first pipeline stage.
  assign sum_data = (state_r == ST_CHKQ) ? signed'(rate_rd) : signed'(res_rd_a);
  assign sum_tgt  = (state_r == ST_CHKQ) ? 36'sd0 : 36'(rme_pkg::ONE_Q24);
  assign sum_tot  = sum_r + 36'(sum_data);
  assign sum_diff = sum_tot - sum_tgt;
  assign row_bad  = (sum_diff > rme_pkg::TOL_LSB) || (sum_diff < -rme_pkg::TOL_LSB);

  // Scaled entry, second stage: round to nearest with ties upward.
  assign sc_n = 6'd24 + 6'(s_r);
  assign sc_v = ((prod + (64'sd1 <<< (sc_n - 6'd1))) >>> sc_n) +
                (s2_diag_r ? rme_pkg::ONE_Q24 : 64'sd0);

  // Squaring product term and running dot product.
  assign sq_r   = (prod + 64'sd8388608) >>> 24;
  assign sq_acc = ((s2_k_r == 2'd0) ? 64'sd0 : acc_r) + sq_r;
  assign scr_we    = s2_v_r && (state_r == ST_SQUARE) && (s2_k_r == 2'd3);
  assign scr_wdata = rme_pkg::sat32(sq_acc);

  always_comb begin
    res_we    = 1'b0;
    res_waddr = s1_idx_r;
    res_wdata = pi_rd;
    case (state_r)
      ST_PIFILL: begin
        res_we = s1_v_r;
      end
      ST_COPY: begin
        res_we    = s1_v_r;
        res_wdata = scr_rd;
      end
      ST_SCALE: begin
        res_we    = s2_v_r;
        res_waddr = s2_idx_r;
        res_wdata = rme_pkg::sat32(sc_v);
      end
      default: begin
        res_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc_in && (in_req_type == rme_pkg::REQ_COMPUTE)) begin
          state_nxt = ST_CHKQ;
        end else if (acc_in && (in_req_type == rme_pkg::REQ_READ)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ:   state_nxt = ST_IDLE;
      ST_CHKQ: begin
        if (drained) begin
          state_nxt = fail_r ? ST_DONE : ST_DECIDE;
        end
      end
      ST_DECIDE: state_nxt = (maxdiag_r > rme_pkg::LONG_LIMIT) ? ST_PIFILL : ST_SSEL;
      ST_SSEL: begin
        if (!((s_r < rme_pkg::MAX_SHIFTS) && (m100_r > (64'd1 << (6'd48 + 6'(s_r)))))) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_PIFILL: if (drained) state_nxt = ST_CHKR;
      ST_SCALE: begin
        if (drained) begin
          state_nxt = (s_r == 4'd0) ? ST_CHKR : ST_SQUARE;
        end
      end
      ST_SQUARE: if (drained) state_nxt = ST_COPY;
      ST_COPY: begin
        if (drained) begin
          state_nxt = (sq_cnt_r + 4'd1 == s_r) ? ST_CHKR : ST_SQUARE;
        end
      end
      ST_CHKR:   if (drained) state_nxt = ST_DONE;
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cnt_r         <= '0;
      s1_v_r        <= 1'b0;
      s2_v_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      last_status_r <= rme_pkg::STAT_OK;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= iss;
      s2_v_r  <= s1_v_r;
      if (state_nxt != state_r) begin
        cnt_r <= '0;
      end else if (iss) begin
        cnt_r <= cnt_r + 7'd1;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_READ) begin
        out_valid_r <= 1'b1;
      end
      if (state_r == ST_DONE) begin
        out_valid_r   <= 1'b1;
        last_status_r <= status_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r  <= iss_idx;
    s1_k_r    <= iss_k;
    s2_idx_r  <= s1_idx_r;
    s2_k_r    <= s1_k_r;
    s2_diag_r <= s1_diag;

    case (state_r)
      ST_IDLE: begin
        if (acc_in && (in_req_type == rme_pkg::REQ_COMPUTE)) begin
          t_r       <= signed'(in_value);
          s_r       <= 4'd0;
          sq_cnt_r  <= 4'd0;
          fail_r    <= 1'b0;
          sum_r     <= '0;
          maxdiag_r <= '0;
        end
      end
      ST_CHKQ: begin
        if (s1_v_r) begin
          sum_r <= (s1_idx_r[1:0] == 2'd3) ? 36'sd0 : sum_tot;
          if ((s1_idx_r[1:0] == 2'd3) && row_bad) begin
            fail_r <= 1'b1;
          end
        end
        if (s2_v_r && s2_diag_r && (prod > maxdiag_r)) begin
          maxdiag_r <= prod;
        end
        if (drained) begin
          status_r <= rme_pkg::STAT_RATE_ROW;
        end
      end
      ST_DECIDE: begin
        m100_r <= (64'(maxdiag_r) << 6) + (64'(maxdiag_r) << 5) + (64'(maxdiag_r) << 2);
      end
      ST_SSEL: begin
        if ((s_r < rme_pkg::MAX_SHIFTS) && (m100_r > (64'd1 << (6'd48 + 6'(s_r))))) begin
          s_r <= s_r + 4'd1;
        end
      end
      ST_SQUARE: begin
        if (s2_v_r) begin
          acc_r <= sq_acc;
        end
      end
      ST_COPY: begin
        if (drained) begin
          sq_cnt_r <= sq_cnt_r + 4'd1;
        end
      end
      ST_CHKR: begin
        if (s1_v_r) begin
          sum_r <= (s1_idx_r[1:0] == 2'd3) ? 36'sd0 : sum_tot;
          if ((s1_idx_r[1:0] == 2'd3) && row_bad) begin
            fail_r <= 1'b1;
          end
        end
        if (drained) begin
          status_r <= fail_r ? rme_pkg::STAT_RES_ROW : rme_pkg::STAT_OK;
        end
      end
      ST_READ: begin
        out_status_r <= last_status_r;
        out_entry_r  <= res_rd_a;
        out_sq_r     <= 4'd0;
      end
      ST_DONE: begin
        out_status_r <= status_r;
        out_entry_r  <= 32'd0;
        out_sq_r     <= s_r;
      end
      default: begin
        sum_r <= sum_r;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_value = out_entry_r;
  assign out_squarings   = out_sq_r;

endmodule

/* dv/testbench.sv */
// ---------------------------------------------------------------------------
// Testbench for rate_matrix_exponential
// Loads random and well-formed rate matrices and stationary vectors, runs
// computes with short and long branch lengths, reads back every result entry
// and compares each response with a predictor kept in the testbench.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  class expm_scoreboard;
    logic signed [31:0] rate_q[16];
    logic signed [31:0] pi_vec[4];
    logic signed [31:0] expm_q[16];
    logic [1:0]         cur_status;
    logic [1:0]         want_status[$];
    logic [31:0]        want_entry[$];
    logic [3:0]         want_sq[$];
    int                 errors;
    int                 checked;

    function new();
      cur_status = rme_pkg::STAT_OK;
      errors = 0;
      checked = 0;
      foreach (rate_q[i]) rate_q[i] = '0;
      foreach (expm_q[i]) expm_q[i] = '0;
      foreach (pi_vec[i]) pi_vec[i] = '0;
    endfunction

    function logic signed [63:0] rnd_shift(logic signed [63:0] x, int n);
      logic signed [63:0] y;
      y = x + (64'sd1 <<< (n - 1));
      return y >>> n;
    endfunction

    function logic signed [31:0] clip(logic signed [63:0] x);
      if (x > 64'sd2147483647) return 32'sh7fffffff;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return x[31:0];
    endfunction

    function bit rows_ok(logic signed [31:0] m[16], logic signed [63:0] target);
      logic signed [63:0] s;
      for (int i = 0; i < 4; i++) begin
        s = -target;
        for (int j = 0; j < 4; j++) s += 64'(m[i*4+j]);
        if (s > 64'sd167 || s < -64'sd167) return 0;
      end
      return 1;
    endfunction

    function void run_expm(logic signed [31:0] t, output logic [1:0] st,
                           output logic [3:0] sq);
      logic signed [63:0] maxdiag, d, p, acc;
      logic signed [31:0] tmp[16];
      int s;
      sq = 4'd0;
      if (!rows_ok(rate_q, 64'sd0)) begin
        st = rme_pkg::STAT_RATE_ROW;
        return;
      end
      maxdiag = 64'sd0;
      for (int i = 0; i < 4; i++) begin
        d = 64'(rate_q[i*5]);
        if (d < 0) d = -d;
        p = d * 64'(t);
        if (maxdiag < p) maxdiag = p;
      end
      s = 0;
      if (maxdiag > (64'sd300 <<< 48)) begin
        for (int i = 0; i < 16; i++) expm_q[i] = pi_vec[i%4];
      end else begin
        while (s < 10 && ($unsigned(maxdiag) * 64'd100) > (64'd1 << (48 + s))) s++;
        for (int i = 0; i < 4; i++)
          for (int j = 0; j < 4; j++) begin
            p = rnd_shift(64'(t) * 64'(rate_q[i*4+j]), 24 + s);
            if (i == j) p += 64'sd16777216;
            expm_q[i*4+j] = clip(p);
          end
        for (int r = 0; r < s; r++) begin
          for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) begin
              acc = 64'sd0;
              for (int k = 0; k < 4; k++)
                acc += rnd_shift(64'(expm_q[i*4+k]) * 64'(expm_q[k*4+j]), 24);
              tmp[i*4+j] = clip(acc);
            end
          expm_q = tmp;
        end
      end
      sq = 4'(s);
      st = rows_ok(expm_q, 64'sd16777216) ? rme_pkg::STAT_OK : rme_pkg::STAT_RES_ROW;
    endfunction

    function void note_request(logic [1:0] rt, logic [1:0] r, logic [1:0] c,
                               logic signed [31:0] v);
      logic [1:0] st;
      logic [3:0] sq;
      case (rt)
        rme_pkg::REQ_WR_RATE: rate_q[r*4+c] = v;
        rme_pkg::REQ_WR_STAT: pi_vec[r] = v;
        rme_pkg::REQ_COMPUTE: begin
          run_expm(v, st, sq);
          cur_status = st;
          want_status.push_back(st);
          want_entry.push_back('0);
          want_sq.push_back(sq);
        end
        default: begin
          want_status.push_back(cur_status);
          want_entry.push_back(expm_q[r*4+c]);
          want_sq.push_back('0);
        end
      endcase
    endfunction

    function void check_response(logic [1:0] st, logic [31:0] ev, logic [3:0] sq);
      checked++;
      if (want_status.size() == 0) begin
        report("response with nothing outstanding");
        return;
      end
      if (st !== want_status[0])
        report($sformatf("status got %0d want %0d", st, want_status[0]));
      if (ev !== want_entry[0])
        report($sformatf("entry got %h want %h", ev, want_entry[0]));
      if (sq !== want_sq[0])
        report($sformatf("squarings got %0d want %0d", sq, want_sq[0]));
      void'(want_status.pop_front());
      void'(want_entry.pop_front());
      void'(want_sq.pop_front());
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch at %0t: %s", $time, msg);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_req_type = rme_pkg::REQ_WR_RATE;
  logic [1:0]  in_row = 0;
  logic [1:0]  in_col = 0;
  logic [31:0] in_value = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  out_status;
  logic [31:0] out_entry_value;
  logic [3:0]  out_squarings;

  expm_scoreboard sb = new();
  int burst_left = 0;
  int computes = 0, bad_rates = 0;

  rate_matrix_exponential dut (.*);

  always #4 clk = ~clk;

  // Receiver stalls in short phases of random length.
  int stall_cnt = 0;
  always @(posedge clk) begin
    if (out_valid && out_ready)
      sb.check_response(out_status, out_entry_value, out_squarings);
    if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
      if ($urandom_range(0, 9) == 0) stall_cnt <= $urandom_range(1, 12);
    end
  end

  task automatic send(logic [1:0] rt, logic [1:0] r, logic [1:0] c, logic [31:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_valid <= 1;
    in_req_type <= rt;
    in_row <= r;
    in_col <= c;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_request(rt, r, c, v);
    if (rt == rme_pkg::REQ_COMPUTE) computes++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.want_status.size() != 0) @(posedge clk);
  endtask

  // Writes a well-formed rate matrix whose rows sum to within 150 of zero; scale sets magnitude.
  task automatic load_rates(int scale);
    logic signed [31:0] off, sum;
    for (int i = 0; i < 4; i++) begin
      sum = 0;
      for (int j = 0; j < 4; j++)
        if (j != i) begin
          off = $urandom_range(0, scale);
          sum += off;
          send(rme_pkg::REQ_WR_RATE, 2'(i), 2'(j), off);
        end
      send(rme_pkg::REQ_WR_RATE, 2'(i), 2'(i),
           -sum + $signed($urandom_range(0, 300)) - 150);
    end
  endtask

  task automatic load_pi();
    for (int i = 0; i < 4; i++)
      send(rme_pkg::REQ_WR_STAT, 2'(i), 2'd0, $urandom_range(0, 1 << 24));
  endtask

  task automatic read_all();
    for (int i = 0; i < 16; i++) send(rme_pkg::REQ_READ, 2'(i / 4), 2'(i % 4), $urandom);
  endtask

  logic [31:0] branch;
  int n;

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: full-scale entries, every request kind, each special case.
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        send(rme_pkg::REQ_WR_RATE, 2'(i), 2'(j), 32'h0);
    send(rme_pkg::REQ_WR_RATE, 2'd0, 2'd1, 32'h7fffffff);
    send(rme_pkg::REQ_WR_RATE, 2'd0, 2'd2, 32'h80000000);
    load_pi();
    send(rme_pkg::REQ_COMPUTE, 2'd0, 2'd0, 32'h0100_0000);
    send(rme_pkg::REQ_WR_RATE, 2'd0, 2'd2, 32'h80000001);
    send(rme_pkg::REQ_COMPUTE, 2'd0, 2'd0, 32'h0100_0000);
    read_all();
    load_rates(1 << 24);
    send(rme_pkg::REQ_COMPUTE, 2'd0, 2'd0, 32'h7fffffff);
    send(rme_pkg::REQ_COMPUTE, 2'd0, 2'd0, 32'h80000000);
    send(rme_pkg::REQ_COMPUTE, 2'd0, 2'd0, 32'h0);
    read_all();
    drain();
    // Random: mostly clean matrices with computes and read-back, some noise.
    n = 0;
    while (n < 450) begin
      case ($urandom_range(0, 9))
        0: begin
          send(rme_pkg::REQ_WR_RATE, 2'($urandom), 2'($urandom), $urandom);
          bad_rates++;
          n++;
        end
        1, 2: begin
          load_rates($urandom_range(0, 3) == 0 ? 32'h0800_0000 : (1 << 22));
          n += 16;
        end
        3: begin
          load_pi();
          n += 4;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: branch = $urandom;
            1: branch = $urandom_range(0, 1 << 20);
            default: branch = $urandom_range(0, 1 << 26);
          endcase
          send(rme_pkg::REQ_COMPUTE, 2'd0, 2'd0, branch);
          for (int k = 0; k < 4; k++)
            send(rme_pkg::REQ_READ, 2'($urandom), 2'($urandom), $urandom);
          n += 5;
        end
      endcase
      if ($urandom_range(0, 40) == 0) drain();
    end
    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d computes, %0d responses checked, %0d random rate writes",
             computes, sb.checked, bad_rates);
    if (sb.errors == 0 && sb.want_status.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d responses outstanding", sb.want_status.size());
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

/* filelist.f */
src/rme_pkg.sv
src/rme_ram.sv
src/rme_mul.sv
src/rate_matrix_exponential.sv
dv/testbench.sv
